// File: rtl/npcm_pkg.sv
// ----------------------------------------------------------------------------
// npcm_pkg
// shared types and constants of the nearest palette colour match block
// ----------------------------------------------------------------------------
package npcm_pkg;

  localparam int COMP_W      = 8;
  localparam int INDEX_W     = 8;
  localparam int DIST_W      = 18;
  localparam int SQ_W        = 2 * COMP_W;
  localparam int NUM_CELLS_W = 9;
  localparam int THR_W       = 7;
  localparam int THR_SQ_W    = 2 * THR_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = NUM_CELLS_W;

  // hard limit on cells in use, whatever the palette depth
  localparam int CELL_LIMIT  = 256;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CELLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_THR = 2'd1;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [NUM_CELLS_W-1:0] RESET_CELLS  = 9'd256;
  localparam logic [THR_SQ_W-1:0]    RESET_THR_SQ = 14'd2500;  // 50 squared

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic              req_type;
    logic [INDEX_W-1:0] cell_index;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } in_word_t;

  typedef struct packed {
    logic [INDEX_W-1:0] best_index;
    logic [DIST_W-1:0]  best_dist_sq;
    logic               within_threshold;
  } out_word_t;

  // control token that travels with each palette entry into the compare unit
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [INDEX_W-1:0] idx;
  } feed_t;

endpackage

// File: rtl/npcm_cell.sv
// ----------------------------------------------------------------------------
// npcm_cell
// one palette entry of the rotating cell chain
// ----------------------------------------------------------------------------
module npcm_cell (
  input  logic           clk,
  input  logic           shift_en,
  input  logic           load_en,
  input  npcm_pkg::rgb_t load_data,
  input  npcm_pkg::rgb_t shift_in,
  output npcm_pkg::rgb_t data_out
);
  import npcm_pkg::*;

  rgb_t data_r;
  rgb_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (load_en) begin
      data_nxt = load_data;
    end else if (shift_en) begin
      data_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

// File: rtl/npcm_dist.sv
// ----------------------------------------------------------------------------
// npcm_dist
// squared rgb distance of the head cell and running minimum, two stages
// ----------------------------------------------------------------------------
module npcm_dist (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  npcm_pkg::feed_t                feed,
  input  npcm_pkg::rgb_t                 head,
  input  npcm_pkg::rgb_t                 qry,
  output logic                           res_valid,
  output logic [npcm_pkg::INDEX_W-1:0]   best_idx,
  output logic [npcm_pkg::DIST_W-1:0]    best_dist
);
  import npcm_pkg::*;

  // stage one: per-component squares
  feed_t           feed_r;
  logic [SQ_W-1:0] sq_r_r, sq_g_r, sq_b_r;
  logic [SQ_W-1:0] sq_r_nxt, sq_g_nxt, sq_b_nxt;
  logic [COMP_W-1:0] dr, dg, db;

  // stage two: running minimum
  logic [INDEX_W-1:0] best_idx_r, best_idx_nxt;
  logic [DIST_W-1:0]  best_dist_r, best_dist_nxt;
  logic               res_valid_r, res_valid_nxt;
  logic [DIST_W-1:0]  dist_sum;

  always_comb begin
    dr = (qry.red   > head.red)   ? qry.red   - head.red   : head.red   - qry.red;
    dg = (qry.green > head.green) ? qry.green - head.green : head.green - qry.green;
    db = (qry.blue  > head.blue)  ? qry.blue  - head.blue  : head.blue  - qry.blue;
    sq_r_nxt = SQ_W'(dr) * SQ_W'(dr);
    sq_g_nxt = SQ_W'(dg) * SQ_W'(dg);
    sq_b_nxt = SQ_W'(db) * SQ_W'(db);
  end

  always_ff @(posedge clk) begin
    sq_r_r <= sq_r_nxt;
    sq_g_r <= sq_g_nxt;
    sq_b_r <= sq_b_nxt;
    if (!rst_n) begin
      feed_r <= '0;
    end else begin
      feed_r <= feed;
    end
  end

  assign dist_sum = DIST_W'(sq_r_r) + DIST_W'(sq_g_r) + DIST_W'(sq_b_r);

  always_comb begin
    best_idx_nxt  = best_idx_r;
    best_dist_nxt = best_dist_r;
    res_valid_nxt = res_valid_r;
    if (start) begin
      // all ones is above any reachable distance
      best_dist_nxt = '1;
      best_idx_nxt  = '0;
      res_valid_nxt = 1'b0;
    end else begin
      // strict compare keeps the lowest index on a tie
      if (feed_r.valid && (dist_sum < best_dist_r)) begin
        best_dist_nxt = dist_sum;
        best_idx_nxt  = feed_r.idx;
      end
      if (feed_r.last) begin
        res_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign best_idx  = best_idx_r;
  assign best_dist = best_dist_r;

endmodule

// File: rtl/nearest_palette_color_match_core.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_match_core
// a write is taken while idle and writes can follow back to back; a query
// holds in_stall while the chain turns and the compare unit drains; its result
// word is registered at the end of that window, one query at a time; the chain
// turns once through all PALETTE_DEPTH cells, one a cycle, then the compare
// unit's square and minimum registers drain; a stalled result word adds its wait
// reset: synchronous, 256 cells and threshold 50, palette undefined until written
// ----------------------------------------------------------------------------
module nearest_palette_color_match_core #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  npcm_pkg::in_word_t                  in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output npcm_pkg::out_word_t                 out_data,
  // configuration port
  input  logic                                cfg_wr_en,
  input  logic [npcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [npcm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import npcm_pkg::*;

  // scan counter width and a compare width that covers both counter and count
  localparam int KW    = (PALETTE_DEPTH > 2) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CMPW  = (KW > NUM_CELLS_W) ? KW : NUM_CELLS_W;
  localparam int LIMIT = (PALETTE_DEPTH < CELL_LIMIT) ? PALETTE_DEPTH : CELL_LIMIT;

  // control states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [KW-1:0] scan_cnt_r, scan_cnt_nxt;
  rgb_t qry_r, qry_nxt;

  logic [NUM_CELLS_W-1:0] num_cells_r, num_cells_nxt;
  logic [THR_SQ_W-1:0]    thr_sq_r, thr_sq_nxt;
  logic [NUM_CELLS_W-1:0] n_use;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;

  logic in_accept, wr_hit, q_start, shift_en, out_free;
  rgb_t wr_rgb;
  rgb_t cell_q [PALETTE_DEPTH];
  feed_t feed;

  logic               res_valid;
  logic [INDEX_W-1:0] best_idx;
  logic [DIST_W-1:0]  best_dist;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  always_comb begin
    num_cells_nxt = num_cells_r;
    thr_sq_nxt    = thr_sq_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_NUM_CELLS: num_cells_nxt = cfg_data;
        // keep the square of the threshold, the compare only needs that
        REG_MATCH_THR: thr_sq_nxt = THR_SQ_W'(cfg_data[THR_W-1:0])
                                    * THR_SQ_W'(cfg_data[THR_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cells_r <= RESET_CELLS;
      thr_sq_r    <= RESET_THR_SQ;
    end else begin
      num_cells_r <= num_cells_nxt;
      thr_sq_r    <= thr_sq_nxt;
    end
  end

  // cells in use: limited to the chain and to CELL_LIMIT, zero treated as one
  always_comb begin
    if (num_cells_r == '0) begin
      n_use = NUM_CELLS_W'(1);
    end else if (num_cells_r > NUM_CELLS_W'(LIMIT)) begin
      n_use = NUM_CELLS_W'(LIMIT);
    end else begin
      n_use = num_cells_r;
    end
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign q_start   = in_accept && (in_data.req_type == REQ_QUERY);
  // writes beyond the cells in use are dropped
  assign wr_hit    = in_accept && (in_data.req_type == REQ_WRITE)
                     && (NUM_CELLS_W'(in_data.cell_index) < n_use);
  assign wr_rgb    = '{red: in_data.red, green: in_data.green, blue: in_data.blue};
  assign shift_en  = (state_r == ST_SCAN);

  // --------------------------------------------------------------------------
  // rotating cell chain, cell 0 is the head seen by the compare unit
  // one full turn of PALETTE_DEPTH shifts brings every entry back home
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
    npcm_cell u_cell (
      .clk       (clk),
      .shift_en  (shift_en),
      .load_en   (wr_hit && (CMPW'(in_data.cell_index) == CMPW'(i))),
      .load_data (wr_rgb),
      .shift_in  (cell_q[(i + 1) % PALETTE_DEPTH]),
      .data_out  (cell_q[i])
    );
  end

  // --------------------------------------------------------------------------
  // scan sequencer
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    feed.valid = shift_en && (CMPW'(scan_cnt_r) < CMPW'(n_use));
    feed.last  = shift_en && (scan_cnt_r == KW'(PALETTE_DEPTH - 1));
    feed.idx   = INDEX_W'(scan_cnt_r);
  end

  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    qry_nxt      = qry_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_start) begin
          state_nxt    = ST_SCAN;
          scan_cnt_nxt = '0;
          qry_nxt      = wr_rgb;
        end
      end
      ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + KW'(1);
        if (feed.last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // wait for the compare pipe to drain and the result slot to free
        if (res_valid && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    scan_cnt_r <= scan_cnt_nxt;
    qry_r      <= qry_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  npcm_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (q_start),
    .feed      (feed),
    .head      (cell_q[0]),
    .qry       (qry_r),
    .res_valid (res_valid),
    .best_idx  (best_idx),
    .best_dist (best_dist)
  );

  // --------------------------------------------------------------------------
  // result register, parts the compare unit from the downstream stall
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == ST_FLUSH) && res_valid && out_free) begin
      out_valid_nxt                 = 1'b1;
      out_data_nxt.best_index       = best_idx;
      out_data_nxt.best_dist_sq     = best_dist;
      out_data_nxt.within_threshold = (best_dist < DIST_W'(thr_sq_r));
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/npcm_checker.sv
// ----------------------------------------------------------------------------
// npcm_checker
// port-level checks of the nearest palette colour match block
// ----------------------------------------------------------------------------
module npcm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input npcm_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input npcm_pkg::out_word_t out_data
);
  import npcm_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // an accepted query blocks the input while the chain scans
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.req_type == REQ_QUERY) |=> in_stall)
    else $error("input not stalled after a query");

  // a palette write leaves the block ready for the next word
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.req_type == REQ_WRITE) |=> !in_stall)
    else $error("input stalled after a write");

  // a match flag implies a distance below the largest threshold squared
  a_flag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.within_threshold |-> (out_data.best_dist_sq < 18'd16129))
    else $error("match flag with too large a distance");

endmodule

bind nearest_palette_color_match_core npcm_checker u_npcm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for nearest_palette_color_match_core: palette writes and
// nearest-colour queries are driven through the valid/stall handshake, a
// scoreboard class keeps its own palette and works out each query's word
// ----------------------------------------------------------------------------
module tb;
  import npcm_pkg::*;

  localparam int PALETTE_DEPTH = 256;
  localparam int ITEM_TARGET   = 850;
  localparam int HOLD_CYCLES   = 900;
  localparam int TAIL_CYCLES   = PALETTE_DEPTH + 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT      = 6;
  localparam int MAX_REPORTS   = 10;

  // register slots beyond the two real ones, writes there must do nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // scoreboard: private palette copy, register copy and pending match words
  class palette_match_board;
    rgb_t        cells [PALETTE_DEPTH];
    bit          written [PALETTE_DEPTH];
    int unsigned num_cells = 32'(RESET_CELLS);
    int unsigned thr       = 50;
    out_word_t   pending_matches [$];
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;

    function int unsigned cells_in_use();
      int unsigned n;
      n = num_cells;
      if (n > CELL_LIMIT) n = CELL_LIMIT;
      if (n > PALETTE_DEPTH) n = PALETTE_DEPTH;
      if (n == 0) n = 1;
      return n;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_NUM_CELLS: num_cells = 32'(val);
        REG_MATCH_THR: thr = 32'(val[THR_W-1:0]);
        default: ;
      endcase
    endfunction

    function int unsigned sq_gap(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b);
      int unsigned g;
      g = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
      return g * g;
    endfunction

    // returns 1 when the word does something (ignored writes return 0)
    function bit note_input(in_word_t w);
      int unsigned n;
      int unsigned d;
      int unsigned best_d;
      int unsigned best;
      out_word_t   res;
      n = cells_in_use();
      if (w.req_type == REQ_WRITE) begin
        if (w.cell_index >= n) return 0;
        cells[w.cell_index].red   = w.red;
        cells[w.cell_index].green = w.green;
        cells[w.cell_index].blue  = w.blue;
        written[w.cell_index] = 1'b1;
        return 1;
      end
      best_d = 32'hFFFF_FFFF;
      best   = 0;
      for (int j = 0; j < n; j++) begin
        d = sq_gap(w.red, cells[j].red) + sq_gap(w.green, cells[j].green) +
            sq_gap(w.blue, cells[j].blue);
        // strict compare keeps the lowest index on a tie
        if (d < best_d) begin
          best_d = d;
          best   = j;
        end
      end
      res.best_index       = best[INDEX_W-1:0];
      res.best_dist_sq     = best_d[DIST_W-1:0];
      res.within_threshold = (best_d < thr * thr);
      pending_matches.push_back(res);
      return 1;
    endfunction

    function void report(string what, out_word_t want, out_word_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s: expected idx %0d dist %0d flag %0d, got idx %0d dist %0d flag %0d",
                 $time, what, want.best_index, want.best_dist_sq, want.within_threshold,
                 got.best_index, got.best_dist_sq, got.within_threshold);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      results_seen++;
      if (pending_matches.size() == 0) begin
        report("result word with nothing expected", '0, got);
        return;
      end
      want = pending_matches.pop_front();
      if (got.best_index !== want.best_index || got.best_dist_sq !== want.best_dist_sq ||
          got.within_threshold !== want.within_threshold)
        report("match word mismatch", want, got);
    endfunction

    function int unsigned pending();
      return pending_matches.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  palette_match_board sb = new();

  bit          quiet      = 1'b0;  // no idling on either side while set
  bit          hold_done  = 1'b0;
  int unsigned items_done = 0;

  nearest_palette_color_match_core #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard limit well beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("FAIL nearest_palette_color_match_core");
    $finish;
  end

  // result side: random stall, plus one long hold-off once results flow
  initial begin
    forever begin
      @(negedge clk);
      if (!hold_done && sb.results_seen >= 30) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        // sender keeps offering words meanwhile, so the core backs up
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= (!quiet && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // result words are taken at the rising edge when valid and not stalled
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_data);
  end

  // offer one word; called at a falling edge, returns at a falling edge
  task automatic send_word(in_word_t w);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.note_input(w)) items_done++;
    @(negedge clk);
  endtask

  task automatic put_cell(int unsigned idx, rgb_t c);
    in_word_t w;
    w.req_type   = REQ_WRITE;
    w.cell_index = idx[INDEX_W-1:0];
    w.red        = c.red;
    w.green      = c.green;
    w.blue       = c.blue;
    send_word(w);
  endtask

  // query cell_index is don't-care, so it carries random bits
  task automatic ask(rgb_t c);
    in_word_t w;
    w.req_type   = REQ_QUERY;
    w.cell_index = INDEX_W'($urandom_range(255));
    w.red        = c.red;
    w.green      = c.green;
    w.blue       = c.blue;
    send_word(w);
  endtask

  function automatic rgb_t any_colour();
    rgb_t c;
    c.red   = COMP_W'($urandom_range(255));
    c.green = COMP_W'($urandom_range(255));
    c.blue  = COMP_W'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [COMP_W-1:0] nudge(logic [COMP_W-1:0] v, int spread);
    int x;
    x = int'(v) + $urandom_range(2 * spread) - spread;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return x[COMP_W-1:0];
  endfunction

  // wait for every match word, then let any write in flight finish
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  // new register setting, then make sure no cell in use is left unwritten
  task automatic configure(int unsigned cells, int unsigned thr_val, bit spare);
    drain();
    write_reg(REG_NUM_CELLS, cells[CFG_DATA_W-1:0]);
    // top bits of the threshold write are junk and must be dropped
    write_reg(REG_MATCH_THR, {2'($urandom_range(3)), thr_val[THR_W-1:0]});
    if (spare) begin
      write_reg(REG_SPARE_A, CFG_DATA_W'($urandom_range(511)));
      write_reg(REG_SPARE_B, CFG_DATA_W'($urandom_range(511)));
    end
    cfg_wr_en <= 1'b0;
    for (int j = 0; j < sb.cells_in_use(); j++)
      if (!sb.written[j]) put_cell(j, any_colour());
  endtask

  task automatic random_item();
    int unsigned n;
    int unsigned sel;
    rgb_t        c;
    n = sb.cells_in_use();
    if ($urandom_range(1)) begin
      sel = $urandom_range(9);
      if (sel < 5) begin
        // near a cell in use, so small distances and the flag show up
        c = sb.cells[$urandom_range(n - 1)];
        sel = $urandom_range(20);
        c.red   = nudge(c.red, sel);
        c.green = nudge(c.green, sel);
        c.blue  = nudge(c.blue, sel);
      end else if (sel == 5) begin
        c.red   = $urandom_range(1) ? 8'hFF : 8'h00;
        c.green = $urandom_range(1) ? 8'hFF : 8'h00;
        c.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
      end else begin
        c = any_colour();
      end
      ask(c);
    end else begin
      // copies of other cells make ties; some writes land out of range
      c = ($urandom_range(4) == 0) ? sb.cells[$urandom_range(n - 1)] : any_colour();
      put_cell(($urandom_range(99) < 80) ? $urandom_range(n - 1) : $urandom_range(255), c);
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned cells;
    int unsigned thr_val;
    int unsigned sel;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setting: 256 cells, threshold 50, black and white at the ends
    put_cell(0, '{8'd0, 8'd0, 8'd0});
    put_cell(255, '{8'd255, 8'd255, 8'd255});
    for (int j = 0; j < PALETTE_DEPTH; j++)
      if (!sb.written[j]) put_cell(j, any_colour());
    ask('{8'd0, 8'd0, 8'd0});
    ask('{8'd255, 8'd255, 8'd255});
    ask(any_colour());

    // zero cells acts as one, zero threshold never flags
    configure(0, 0, 1'b1);
    put_cell(1, '{8'd12, 8'd34, 8'd56});
    put_cell(0, '{8'd255, 8'd0, 8'd255});
    put_cell(255, '{8'd1, 8'd2, 8'd3});
    ask('{8'd0, 8'd255, 8'd0});   // largest possible distance
    ask('{8'd255, 8'd0, 8'd255}); // exact hit

    // five cells: ties go to the lower index, flag edge at threshold squared
    configure(5, 10, 1'b0);
    put_cell(0, '{8'd10, 8'd10, 8'd10});
    put_cell(1, '{8'd30, 8'd10, 8'd10});
    put_cell(2, '{8'd30, 8'd10, 8'd10});
    put_cell(3, '{8'd200, 8'd200, 8'd200});
    put_cell(4, '{8'd7, 8'd7, 8'd1});
    ask('{8'd20, 8'd10, 8'd10});
    ask('{8'd0, 8'd0, 8'd0});
    ask('{8'd30, 8'd10, 8'd10});
    ask('{8'd200, 8'd200, 8'd210});
    ask('{8'd200, 8'd200, 8'd209});

    // cell count above the limit clamps, threshold at the top of its range
    configure(511, 127, 1'b1);
    ask('{8'd128, 8'd128, 8'd128});
    ask('{8'd1, 8'd254, 8'd3});

    phase = 0;
    while (items_done < ITEM_TARGET) begin
      sel = $urandom_range(9);
      if (sel == 0)      cells = 256;
      else if (sel == 1) cells = $urandom_range(257, 511);
      else if (sel == 2) cells = 0;
      else if (sel == 3) cells = 1;
      else               cells = $urandom_range(2, 24);
      sel = $urandom_range(7);
      if (sel == 0)      thr_val = 0;
      else if (sel == 1) thr_val = 127;
      else if (sel == 2) thr_val = 100;
      else               thr_val = $urandom_range(127);
      configure(cells, thr_val, (phase % 3) == 0);
      quiet = (phase == 1);
      repeat ($urandom_range(30, 120)) random_item();
      quiet = 1'b0;
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("PASS nearest_palette_color_match_core");
    else
      $display("FAIL nearest_palette_color_match_core");
    $finish;
  end

endmodule

// File: files.f
rtl/npcm_pkg.sv
rtl/npcm_cell.sv
rtl/npcm_dist.sv
rtl/nearest_palette_color_match_core.sv
rtl/npcm_checker.sv
tb/sv/tb.sv
